// File: hw/rtl/hdri_pkg.sv
// Shared types and constants for the heading dead-reckoning integrator.
package hdri_pkg;

  localparam int CORD_STEPS = 15;
  localparam int STEP_W     = $clog2(CORD_STEPS);
  localparam int CORD_W     = 18;

  localparam logic signed [CORD_W-1:0] CORD_ONE     = 18'sd19898;
  localparam logic signed [CORD_W-1:0] QUARTER_TURN = 18'sd16384;
  localparam logic signed [CORD_W-1:0] HALF_TURN    = 18'sd32768;

  // arctangent of 2^-i in binary-angle units
  localparam logic signed [CORD_W-1:0] ATAN_TAB [CORD_STEPS] = '{
    18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
    18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1
  };

  localparam logic [31:0] DT_MAX = 32'd65535;
  localparam int DT_W = 16;

  localparam int VEL_W = 17;
  localparam int IN_W  = 112;
  localparam int OUT_W = 200;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
    logic                     flip;
  } cordic_t;

endpackage

// File: hw/rtl/hdri_cordic_cell.sv
// One CORDIC rotation cell: a registered micro-rotation by atan(2^-step).
module hdri_cordic_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [hdri_pkg::STEP_W-1:0]   step,
  input  logic                          in_vld,
  input  hdri_pkg::cordic_t             din,
  output logic                          out_vld,
  output hdri_pkg::cordic_t             dout
);
  import hdri_pkg::*;

  logic                     vld_r;
  cordic_t                  dat_r, dat_nxt;
  logic signed [CORD_W-1:0] dx, dy, ang;

  always_comb begin
    // arithmetic shift is floor toward minus infinity
    dx  = din.y >>> step;
    dy  = din.x >>> step;
    ang = ATAN_TAB[step];
    dat_nxt.flip = din.flip;
    if (!din.z[CORD_W-1]) begin
      dat_nxt.x = din.x - dx;
      dat_nxt.y = din.y + dy;
      dat_nxt.z = din.z - ang;
    end else begin
      dat_nxt.x = din.x + dx;
      dat_nxt.y = din.y - dy;
      dat_nxt.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_vld = vld_r;
  assign dout    = dat_r;

endmodule

// File: hw/rtl/hdri_cordic_chain.sv
// Row of CORDIC cells producing cosine and sine of a binary angle in Q1.15.
module hdri_cordic_chain (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [15:0]                  ang,
  output logic                                done,
  output logic signed [hdri_pkg::CORD_W-1:0]  cos_o,
  output logic signed [hdri_pkg::CORD_W-1:0]  sin_o
);
  import hdri_pkg::*;

  cordic_t                  stage [CORD_STEPS+1];
  cordic_t                  seed;
  logic [CORD_STEPS:0]      vld;
  logic signed [CORD_W-1:0] za;

  // fold into the right half-plane; undone by negating both outputs
  always_comb begin
    za = CORD_W'(ang);
    seed.x = CORD_ONE;
    seed.y = '0;
    if (za > QUARTER_TURN) begin
      seed.z    = za - HALF_TURN;
      seed.flip = 1'b1;
    end else if (za < -QUARTER_TURN) begin
      seed.z    = za + HALF_TURN;
      seed.flip = 1'b1;
    end else begin
      seed.z    = za;
      seed.flip = 1'b0;
    end
  end

  assign stage[0] = seed;
  assign vld[0]   = start;

  for (genvar i = 0; i < CORD_STEPS; i++) begin : g_cell
    hdri_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (STEP_W'(i)),
      .in_vld  (vld[i]),
      .din     (stage[i]),
      .out_vld (vld[i+1]),
      .dout    (stage[i+1])
    );
  end

  assign done  = vld[CORD_STEPS];
  assign cos_o = stage[CORD_STEPS].flip ? -stage[CORD_STEPS].x : stage[CORD_STEPS].x;
  assign sin_o = stage[CORD_STEPS].flip ? -stage[CORD_STEPS].y : stage[CORD_STEPS].y;

  // one angle in flight at a time
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld[CORD_STEPS:1]))
    else $error("more than one angle in the CORDIC row");

  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (vld[CORD_STEPS:1] == '0))
    else $error("CORDIC started while busy");

endmodule

// File: hw/rtl/heading_dead_reckoning_integrator.sv
// Top level: velocity rotation by heading and saturating position integration.
//
// Each input transfer carries a body-frame velocity pair, a binary-angle heading and two
// tick stamps. Sine and cosine come from a row of 15 CORDIC cells; the rotated velocities
// are rounded half up to whole units and clamped to +/-46341, then multiplied by the
// elapsed ticks (now minus prev modulo 2^32, limited to 65535) and added to two signed
// 64-bit sums that saturate. Reset clears both sums. One result transfer follows each
// input transfer and reports the new sums. An item passes from acceptance through the
// CORDIC row, the single shared 18x18 multiplier, rounding and the accumulate, and the
// block returns to idle before it accepts the next item. The accumulate waits while an
// earlier result is still untaken. A finished result sits in an output register, so
// the next item is accepted while it waits to be taken.
module heading_dead_reckoning_integrator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // body_vel_x[15:0], body_vel_y[31:16], heading[47:32], prev_time[79:48],
  // now_time[111:80]
  input  logic [hdri_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // north_vel[16:0], east_vel[33:17], east_position[97:34], north_position[161:98],
  // stamp[193:162], zero fill[199:194]
  output logic [hdri_pkg::OUT_W-1:0]   out_tdata
);
  import hdri_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_DTM  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;

  localparam int MUL_W = 2 * CORD_W;
  localparam logic signed [21:0] VEL_LIM = 22'sd46341;

  logic [2:0]                state_r, state_nxt;
  logic [1:0]                cnt_r;
  logic                      out_vld_r;
  logic [OUT_W-1:0]          out_data_r;

  logic signed [15:0]        vx_r, vy_r;
  logic [DT_W-1:0]           dt_r;
  logic [31:0]               stamp_r;
  logic signed [CORD_W-1:0]  cos_r, sin_r;
  logic signed [MUL_W-1:0]   accn_r, acce_r, dn_r, de_r;
  logic signed [VEL_W-1:0]   vn_r, ve_r;
  logic signed [63:0]        east_sum_r, north_sum_r;
  logic signed [63:0]        east_new, north_new;

  logic                      in_xfer, out_free;
  logic                      cord_done;
  logic signed [CORD_W-1:0]  cord_cos, cord_sin;
  logic [31:0]               diff;
  logic [DT_W-1:0]           dt_in;
  logic signed [CORD_W-1:0]  mul_a, mul_b;
  logic signed [MUL_W-1:0]   mul_p;

  function automatic logic signed [VEL_W-1:0] round_vel(input logic signed [MUL_W-1:0] a);
    logic signed [MUL_W:0] t;
    logic signed [21:0]    q;
    t = (MUL_W+1)'(a) + (MUL_W+1)'(16384);
    q = 22'(t >>> 15);
    if (q > VEL_LIM) begin
      q = VEL_LIM;
    end else if (q < -VEL_LIM) begin
      q = -VEL_LIM;
    end
    return VEL_W'(q);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [MUL_W-1:0] b);
    logic signed [63:0] be, s;
    be = 64'(b);
    s  = a + be;
    if ((a[63] == be[63]) && (s[63] != a[63])) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  hdri_cordic_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .ang   (in_tdata[47:32]),
    .done  (cord_done),
    .cos_o (cord_cos),
    .sin_o (cord_sin)
  );

  assign diff  = in_tdata[111:80] - in_tdata[79:48];
  assign dt_in = (diff > DT_MAX) ? DT_MAX[DT_W-1:0] : diff[DT_W-1:0];

  // shared multiplier: four rotation products, then two velocity*ticks products
  always_comb begin
    if (state_r == S_DTM) begin
      mul_a = cnt_r[0] ? CORD_W'(ve_r) : CORD_W'(vn_r);
      mul_b = $signed({{(CORD_W-DT_W){1'b0}}, dt_r});
    end else begin
      mul_a = cnt_r[0] ? CORD_W'(vy_r) : CORD_W'(vx_r);
      mul_b = (cnt_r == 2'd1 || cnt_r == 2'd2) ? sin_r : cos_r;
    end
  end

  assign mul_p = mul_a * mul_b;

  assign east_new  = sat_add(east_sum_r, de_r);
  assign north_new = sat_add(north_sum_r, dn_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_CORD;
      S_CORD: if (cord_done) state_nxt = S_MUL;
      S_MUL:  if (cnt_r == 2'd3) state_nxt = S_RND;
      S_RND:  state_nxt = S_DTM;
      S_DTM:  if (cnt_r[0]) state_nxt = S_ACC;
      S_ACC:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_vld_r   <= 1'b0;
      east_sum_r  <= '0;
      north_sum_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_MUL) || (state_r == S_DTM)) begin
        cnt_r <= cnt_r + 2'd1;
      end else begin
        cnt_r <= '0;
      end
      if (state_r == S_ACC && out_free) begin
        out_vld_r   <= 1'b1;
        east_sum_r  <= east_new;
        north_sum_r <= north_new;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vx_r    <= in_tdata[15:0];
      vy_r    <= in_tdata[31:16];
      dt_r    <= dt_in;
      stamp_r <= in_tdata[111:80];
    end
    if (state_r == S_CORD && cord_done) begin
      cos_r <= cord_cos;
      sin_r <= cord_sin;
    end
    if (state_r == S_MUL) begin
      unique case (cnt_r)
        2'd0: accn_r <= mul_p;
        2'd1: accn_r <= accn_r - mul_p;
        2'd2: acce_r <= mul_p;
        2'd3: acce_r <= acce_r + mul_p;
        default: accn_r <= mul_p;
      endcase
    end
    if (state_r == S_RND) begin
      vn_r <= round_vel(accn_r);
      ve_r <= round_vel(acce_r);
    end
    if (state_r == S_DTM) begin
      if (cnt_r[0]) begin
        de_r <= mul_p;
      end else begin
        dn_r <= mul_p;
      end
    end
    if (state_r == S_ACC && out_free) begin
      out_data_r <= {{(OUT_W-2*VEL_W-128-32){1'b0}}, stamp_r, north_new, east_new,
                     ve_r, vn_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_cord_state: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == S_CORD))
    else $error("CORDIC result outside the wait state");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == S_ACC))
    else $error("result raised outside accumulate");

  a_east_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && out_free && !east_sum_r[63] && !de_r[MUL_W-1])
      |=> !east_sum_r[63])
    else $error("east sum wrapped negative");

  a_north_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && out_free && north_sum_r[63] && dn_r[MUL_W-1])
      |=> north_sum_r[63])
    else $error("north sum wrapped positive");

endmodule

// File: bench/tb_heading_dead_reckoning_integrator.sv
// Self-checking bench for the heading dead-reckoning integrator stream block.
`timescale 1ns / 1ps

module tb_heading_dead_reckoning_integrator;
  import hdri_pkg::*;

  localparam int           CYCLE_LIMIT = 500000;
  localparam int           MSG_CAP     = 20;
  localparam longint       VEL_LIM     = 46341;
  localparam logic [63:0]  POS_MAX     = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0]  POS_MIN     = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [VEL_W-1:0] vn;
    logic signed [VEL_W-1:0] ve;
    logic signed [63:0]      east_pos;
    logic signed [63:0]      north_pos;
    logic [31:0]             stamp;
  } fix_t;

  // typed: expected velocities and sums given in the row; stamp is always now
  typedef struct packed {
    logic        typed;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] hd;
    logic [31:0] prv;
    logic [31:0] nw;
    logic [16:0] t_vn;
    logic [16:0] t_ve;
    logic [63:0] t_e;
    logic [63:0] t_n;
  } stim_row_t;

  localparam int DIR_ROWS = 20;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // zero motion right after reset: everything stays zero
    '{1'b1, 16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b1, 16'h0000, 16'h0000, 16'h8000, 32'd5, 32'd4, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b1, 16'h0000, 16'h0000, 16'h7fff, 32'd0, 32'd65535, 17'd0, 17'd0, 64'd0, 64'd0},
    // heading zero, one tick, then exactly the elapsed cap
    '{1'b0, 16'h7fff, 16'h0000, 16'h0000, 32'd100, 32'd101, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h8000, 16'h0000, 16'h0000, 32'd101, 32'd65636, 17'd0, 17'd0, 64'd0, 64'd0},
    // exactly +/-90 degrees (no flip), then just beyond (flip)
    '{1'b0, 16'h0000, 16'h7fff, 16'h4000, 32'd65636, 32'd66636, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h0000, 16'h8000, 16'hc000, 32'd66636, 32'd67636, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h7fff, 16'h7fff, 16'h4001, 32'd67636, 32'd68636, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h8000, 16'h8000, 16'hbfff, 32'd68636, 32'd69636, 17'd0, 17'd0, 64'd0, 64'd0},
    // 45 degree diagonals with full-scale inputs: velocity clamp region, then a half turn
    '{1'b0, 16'h8000, 16'h7fff, 16'h2000, 32'd69636, 32'd70636, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h8000, 16'h8000, 16'he000, 32'd70636, 32'd71636, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h7fff, 16'h8000, 16'h6000, 32'd71636, 32'd72636, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h8000, 16'h8000, 16'ha000, 32'd72636, 32'd73636, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 32'd73636, 32'd74636, 17'd0, 17'd0, 64'd0, 64'd0},
    // tick counter wrapping forward, and time running backwards
    '{1'b0, 16'h0001, 16'hffff, 16'h7fff, 32'hffff_fff0, 32'h0000_0010,
      17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'hffff, 16'h0001, 16'h0001, 32'd0, 32'hffff_ffff, 17'd0, 17'd0, 64'd0, 64'd0},
    // no elapsed ticks, one past the cap
    '{1'b0, 16'h3039, 16'ha460, 16'hcfc7, 32'd7, 32'd7, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h8000, 16'h8000, 16'h0000, 32'd1000, 32'd66536, 17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'h5555, 16'haaaa, 16'h5555, 32'haaaa_aaaa, 32'h5555_5555,
      17'd0, 17'd0, 64'd0, 64'd0},
    '{1'b0, 16'haaaa, 16'h5555, 16'haaaa, 32'h5555_5555, 32'haaaa_aaaa,
      17'd0, 17'd0, 64'd0, 64'd0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  fix_t        fix_q[$];
  longint      east_acc;
  longint      north_acc;
  logic [31:0] clock_now;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_req;
  int          hold_left;
  int          errors;
  int          cyc;

  heading_dead_reckoning_integrator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    if (errors <= MSG_CAP)
      $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // CORDIC sine/cosine in Q1.15, folded into +/-90 degrees
  function automatic void heading_sincos(input int ang, output int cs, output int sn);
    int x;
    int y;
    int z;
    int dx;
    int dy;
    bit flip;
    x = CORD_ONE;
    y = 0;
    z = ang;
    flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < CORD_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TAB[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TAB[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint round_vel(input longint p);
    longint v;
    v = (p + 64'sd16384) >>> 15;
    if (v > VEL_LIM) v = VEL_LIM;
    if (v < -VEL_LIM) v = -VEL_LIM;
    return v;
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? POS_MIN : POS_MAX;
    return s;
  endfunction

  // advances the position sums and returns the fix this transfer should produce
  function automatic fix_t predict_fix(input logic [IN_W-1:0] d);
    longint      vx;
    longint      vy;
    longint      vn;
    longint      ve;
    longint      dt;
    int          cs;
    int          sn;
    logic [31:0] span;
    fix_t        f;
    vx = longint'($signed(d[15:0]));
    vy = longint'($signed(d[31:16]));
    heading_sincos(int'($signed(d[47:32])), cs, sn);
    vn = round_vel(vx * cs - vy * sn);
    ve = round_vel(vx * sn + vy * cs);
    span = d[111:80] - d[79:48];
    if (span > DT_MAX) span = DT_MAX;
    dt = {32'd0, span};
    east_acc = sat_sum(east_acc, ve * dt);
    north_acc = sat_sum(north_acc, vn * dt);
    f.vn = vn[VEL_W-1:0];
    f.ve = ve[VEL_W-1:0];
    f.east_pos = east_acc;
    f.north_pos = north_acc;
    f.stamp = d[111:80];
    return f;
  endfunction

  task automatic check_fix(input logic [OUT_W-1:0] t);
    fix_t want;
    if (fix_q.size() == 0) begin
      flag_mismatch("unexpected result", t[63:0], 64'd0);
      return;
    end
    want = fix_q.pop_front();
    if (t[16:0] !== want.vn)
      flag_mismatch("north_vel", {47'd0, t[16:0]}, {47'd0, want.vn});
    if (t[33:17] !== want.ve)
      flag_mismatch("east_vel", {47'd0, t[33:17]}, {47'd0, want.ve});
    if (t[97:34] !== want.east_pos)
      flag_mismatch("east_position", t[97:34], want.east_pos);
    if (t[161:98] !== want.north_pos)
      flag_mismatch("north_position", t[161:98], want.north_pos);
    if (t[193:162] !== want.stamp)
      flag_mismatch("stamp", {32'd0, t[193:162]}, {32'd0, want.stamp});
    if (t[199:194] !== 6'd0)
      flag_mismatch("zero fill", {58'd0, t[199:194]}, 64'd0);
  endtask

  // result side: random backpressure plus long hold-offs on request
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_fix(out_tdata);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (!rst_n || hold_left != 0) begin
        if (hold_left != 0) hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  task automatic offer_item(input logic [IN_W-1:0] d);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_vel();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9, 0))
      0: r = 32'h8000;
      1: r = 32'h7fff;
      2: r = $urandom_range(64, 0) - 32'd32;
      default: ;
    endcase
    return r[15:0];
  endfunction

  function automatic logic [15:0] pick_heading();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9, 0))
      0: r = 32'h4000 + $urandom_range(4, 0) - 32'd2;
      1: r = 32'hc000 + $urandom_range(4, 0) - 32'd2;
      2: r = 32'h8000 + $urandom_range(4, 0) - 32'd2;
      default: ;
    endcase
    return r[15:0];
  endfunction

  // tick stamps mostly follow a running clock; some jump, wrap or go backwards
  task automatic make_item(output logic [IN_W-1:0] d);
    logic [31:0] prv;
    logic [31:0] nw;
    prv = clock_now;
    case ($urandom_range(9, 0))
      7: nw = prv + $urandom_range(70000, 60000);
      8: begin
        prv = $urandom;
        nw = $urandom;
      end
      9: nw = prv - $urandom_range(1000, 1);
      default: nw = prv + $urandom_range(2000, 0);
    endcase
    clock_now = nw;
    d = {nw, prv, pick_heading(), pick_vel(), pick_vel()};
  endtask

  initial begin
    logic [IN_W-1:0] d;
    fix_t            f;
    stim_row_t       r;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    tx_idle_pct = 22;
    rx_idle_pct = 59;
    hold_req = 0;
    errors = 0;
    east_acc = 0;
    north_acc = 0;
    clock_now = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      r = DIR_TAB[i];
      d = {r.nw, r.prv, r.hd, r.vy, r.vx};
      offer_item(d);
      f = predict_fix(d);
      if (r.typed) f = '{r.t_vn, r.t_ve, r.t_e, r.t_n, r.nw};
      fix_q.push_back(f);
    end

    for (int n = 0; n < 1200; n++) begin
      if (n == 400) begin
        tx_idle_pct = 59;
        rx_idle_pct = 22;
      end
      if (n == 800) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long result stall while transfers keep coming
      if (n == 150 || n == 700) hold_req = 400;
      // sender goes quiet until the block has drained
      if (n == 300 || n == 1000) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (fix_q.size() != 0) @(posedge clk);
      end
      make_item(d);
      offer_item(d);
      fix_q.push_back(predict_fix(d));
    end

    in_tvalid <= 1'b0;
    while (fix_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
